// ----- sv/q32sq_pkg.sv -----
// Shared types and constants for the Q32.32 square root pipeline.
// No dependencies.
package q32sq_pkg;

	localparam logic [63:0] NAN_CODE      = 64'h8000_0000_0000_0000;
	localparam logic [63:0] HALF_UNIT     = 64'h0000_0000_8000_0000;
	localparam int          FIRST_BIT_LOG = 62;
	localparam int          SECOND_BIT_LOG = 30;
	localparam int          PASS1_STEPS   = 32;
	localparam int          PASS2_STEPS   = 16;
	localparam int          NUM_LINKS     = PASS1_STEPS + PASS2_STEPS + 2;

	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] acc;
		logic        bad;
	} stage_t;

endpackage

// ----- sv/q32sq_ifs.sv -----
// Valid/ready channel interfaces for the operand and result streams.
// No dependencies.
interface q32sq_in_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] operand;

	modport source (output valid, output operand, input ready);
	modport sink   (input valid, input operand, output ready);
endinterface

interface q32sq_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] root;
	logic               invalid;

	modport source (output valid, output root, output invalid, input ready);
	modport sink   (input valid, input root, input invalid, output ready);
endinterface

// ----- sv/q32sq_step.sv -----
// One digit of the square root recurrence, with its pipeline register.
// Depends on q32sq_pkg.
module q32sq_step (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [63:0]      weight,
	input  logic             vld_in,
	input  q32sq_pkg::stage_t dat_in,
	output logic             vld_s1,
	output q32sq_pkg::stage_t dat_s1
);
	import q32sq_pkg::*;

	logic [63:0] trial;
	stage_t      nxt;

	always_comb begin
		trial = dat_in.acc + weight;
		nxt   = dat_in;
		if (dat_in.rem >= trial) begin
			nxt.rem = dat_in.rem - trial;
			nxt.acc = {1'b0, dat_in.acc[63:1]} + weight;
		end else begin
			nxt.acc = {1'b0, dat_in.acc[63:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_s1 <= nxt;
		end
	end

endmodule

// ----- sv/q32sq_fix.sv -----
// Rescales remainder and root by 2^32 between the two passes, moving a
// half unit into the root when the remainder is too wide. Depends on q32sq_pkg.
module q32sq_fix (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  q32sq_pkg::stage_t dat_in,
	output logic             vld_s1,
	output q32sq_pkg::stage_t dat_s1
);
	import q32sq_pkg::*;

	logic [63:0] diff;
	stage_t      nxt;

	always_comb begin
		diff = dat_in.rem - dat_in.acc;
		nxt  = dat_in;
		if (dat_in.rem[63:32] != 32'd0) begin
			nxt.rem = {diff[31:0], 32'd0} - HALF_UNIT;
			nxt.acc = {dat_in.acc[31:0], 32'd0} + HALF_UNIT;
		end else begin
			nxt.rem = {dat_in.rem[31:0], 32'd0};
			nxt.acc = {dat_in.acc[31:0], 32'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_s1 <= nxt;
		end
	end

endmodule

// ----- sv/q32sq_round.sv -----
// Round-to-nearest step and invalid substitution; holds the output register.
// Depends on q32sq_pkg.
module q32sq_round (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  q32sq_pkg::stage_t dat_in,
	output logic             vld_s1,
	output logic [63:0]      root_s1,
	output logic             invalid_s1
);
	import q32sq_pkg::*;

	logic [63:0] rounded;

	always_comb begin
		rounded = dat_in.acc + {63'd0, (dat_in.rem > dat_in.acc)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_s1    <= dat_in.bad ? NAN_CODE : rounded;
			invalid_s1 <= dat_in.bad;
		end
	end

endmodule

// ----- sv/q32_32_square_root.sv -----
// Q32.32 square root, rounded to nearest. Fully pipelined: one operand is
// taken per cycle unless the pipeline stalls, and each result passes through
// 32 integer digit stages, one rescale stage, 16 fraction digit stages and
// one rounding/output stage, one recurrence digit per digit stage. The whole
// pipeline advances together; arg.ready is low only while a result sits on
// res unaccepted. Negative operands and the not-a-number code give root
// 0x8000000000000000 with invalid set. No state between items.
// Depends on q32sq_pkg, q32sq_ifs, q32sq_step, q32sq_fix, q32sq_round.
module q32_32_square_root (
	input  logic        clk,
	input  logic        arst_n,
	q32sq_in_if.sink    arg,
	q32sq_out_if.source res
);
	import q32sq_pkg::*;

	localparam int FIX_LINK = PASS1_STEPS + 1;
	localparam int LAST_LINK = NUM_LINKS - 1;

	logic        en;
	logic        vld [0:LAST_LINK];
	stage_t      st  [0:LAST_LINK];
	logic        out_vld;
	logic [63:0] out_root;
	logic        out_invalid;

	assign en = !out_vld || res.ready;
	assign arg.ready = en;

	assign vld[0]    = arg.valid;
	assign st[0].rem = {1'b0, arg.operand[62:0]};
	assign st[0].acc = 64'd0;
	assign st[0].bad = arg.operand[63];

	for (genvar i = 0; i < PASS1_STEPS; i++) begin : g_pass1
		localparam logic [63:0] WEIGHT = 64'd1 << (FIRST_BIT_LOG - 2 * i);
		q32sq_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.weight (WEIGHT),
			.vld_in (vld[i]),
			.dat_in (st[i]),
			.vld_s1 (vld[i + 1]),
			.dat_s1 (st[i + 1])
		);
	end

	q32sq_fix u_fix (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_in (vld[PASS1_STEPS]),
		.dat_in (st[PASS1_STEPS]),
		.vld_s1 (vld[FIX_LINK]),
		.dat_s1 (st[FIX_LINK])
	);

	for (genvar j = 0; j < PASS2_STEPS; j++) begin : g_pass2
		localparam logic [63:0] WEIGHT = 64'd1 << (SECOND_BIT_LOG - 2 * j);
		q32sq_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.weight (WEIGHT),
			.vld_in (vld[FIX_LINK + j]),
			.dat_in (st[FIX_LINK + j]),
			.vld_s1 (vld[FIX_LINK + j + 1]),
			.dat_s1 (st[FIX_LINK + j + 1])
		);
	end

	q32sq_round u_round (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.vld_in     (vld[LAST_LINK]),
		.dat_in     (st[LAST_LINK]),
		.vld_s1     (out_vld),
		.root_s1    (out_root),
		.invalid_s1 (out_invalid)
	);

	assign res.valid   = out_vld;
	assign res.root    = out_root;
	assign res.invalid = out_invalid;

`ifndef SYNTHESIS
	// integer pass leaves remainder within 2*root
	a_pass1_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld[PASS1_STEPS] && !st[PASS1_STEPS].bad
			|-> st[PASS1_STEPS].rem <= {st[PASS1_STEPS].acc[62:0], 1'b0})
		else $error("remainder out of range after integer pass");

	a_fix_low: assert property (@(posedge clk) disable iff (!arst_n)
		vld[FIX_LINK] && !st[FIX_LINK].bad |-> st[FIX_LINK].acc[30:0] == 31'd0)
		else $error("rescaled root has stray low bits");

	a_invalid_code: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.invalid |-> res.root == NAN_CODE)
		else $error("invalid result without not-a-number code");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.invalid |-> res.root[63:48] == 16'd0)
		else $error("root exceeds 48 bits");
`endif

endmodule

// ----- sim/tb_q32_32_square_root.sv -----
// Self-checking testbench for q32_32_square_root: directed and random operands,
// predicted roots compared field by field on every result transfer.
// Depends on q32sq_pkg, q32sq_ifs and the q32_32_square_root RTL.
`timescale 1ns / 100ps

module tb_q32_32_square_root;
	import q32sq_pkg::*;

	localparam logic [63:0] FRAC_ROOM  = 64'h0000_0000_FFFF_FFFF;
	localparam logic [63:0] ISQRT_MAX  = 64'h0000_0000_B504_F333;
	localparam int          N_RANDOM   = 1880;
	localparam int          DRAIN_CYC  = 60;
	localparam int          HOLD_CYC   = 240;
	localparam int          HOLD_AT    = 400;
	localparam int          CALM_FROM  = 900;
	localparam int          CALM_TO    = 1200;

	typedef struct {
		logic [63:0] operand;
		logic [63:0] root;
		logic        invalid;
	} root_rec_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic               in_valid   = 1'b0;
	logic signed [63:0] in_operand = '0;
	logic               out_ready  = 1'b0;

	q32sq_in_if  arg_ch ();
	q32sq_out_if res_ch ();

	assign arg_ch.valid   = in_valid;
	assign arg_ch.operand = in_operand;
	assign res_ch.ready   = out_ready;

	q32_32_square_root u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.arg    (arg_ch.sink),
		.res    (res_ch.source)
	);

	logic [63:0] pending_operands[$];
	root_rec_t   expected_roots[$];
	int          sent       = 0;
	int          mismatches = 0;
	int          hold_left  = 0;
	logic        hold_done  = 1'b0;
	logic        calm;

	assign calm = (sent >= CALM_FROM) && (sent < CALM_TO);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// one pass of the restoring digit recurrence, weight w down to 1
	function automatic void digit_pass(inout logic [63:0] r, inout logic [63:0] u,
			input logic [63:0] w);
		logic [63:0] trial;
		while (w != 64'd0) begin
			trial = u + w;
			if (r >= trial) begin
				r = r - trial;
				u = (u >> 1) + w;
			end else begin
				u = u >> 1;
			end
			w = w >> 2;
		end
	endfunction

	function automatic root_rec_t expected_root(input logic [63:0] x);
		root_rec_t   e;
		logic [63:0] r;
		logic [63:0] u;
		logic [63:0] w;
		e.operand = x;
		e.invalid = x[63];
		e.root    = NAN_CODE;
		if (!x[63]) begin
			r = x;
			u = '0;
			w = 64'd1 << FIRST_BIT_LOG;
			while (w > r)
				w = w >> 2;
			digit_pass(r, u, w);
			if (r > FRAC_ROOM) begin
				r = ((r - u) << 32) - HALF_UNIT;
				u = (u << 32) + HALF_UNIT;
			end else begin
				r = r << 32;
				u = u << 32;
			end
			digit_pass(r, u, 64'd1 << SECOND_BIT_LOG);
			if (r > u)
				u = u + 64'd1;
			e.root = u;
		end
		return e;
	endfunction

	function automatic logic [63:0] random_operand();
		logic [63:0] k;
		logic [63:0] x;
		int          pick;
		pick = $urandom_range(99);
		x = {$urandom, $urandom};
		if (pick < 15) begin
			// full range, negatives included
		end else if (pick < 40) begin
			x[63] = 1'b0;
		end else if (pick < 60) begin
			x[63] = 1'b0;
			x = x >> $urandom_range(63, 0);
		end else if (pick < 80) begin
			// perfect squares and their neighbors
			k = 64'($urandom_range(ISQRT_MAX[31:0], 0));
			if ($urandom_range(1))
				k = k >> $urandom_range(31, 0);
			x = k * k + 64'($signed($urandom_range(4, 0)) - 2);
			x[63] = 1'b0;
		end else if (pick < 90) begin
			x = {22'd0, 10'($urandom_range(1023)), $urandom};
		end else begin
			x = $urandom_range(3) == 0 ? NAN_CODE : -64'($urandom_range(65535, 1));
		end
		return x;
	endfunction

	initial begin
		logic [63:0] b;
		b = 64'h0000_0000_B000_0000;
		pending_operands = '{
			64'd0, 64'd1, 64'd2, 64'd3, 64'd4,
			64'h7FFF_FFFF_FFFF_FFFF, NAN_CODE, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h8000_0000_0000_0001, 64'h0000_0001_0000_0000,
			64'h0000_0002_0000_0000, 64'h0000_0004_0000_0000,
			64'h0000_0000_4000_0000, 64'h0000_0000_8000_0000,
			64'h4000_0000_0000_0000, 64'h3FFF_FFFF_FFFF_FFFF,
			ISQRT_MAX * ISQRT_MAX, ISQRT_MAX * ISQRT_MAX - 64'd1,
			b * b + 2 * b, b * b + 2 * b + 64'd1,
			64'h5555_5555_5555_5555, 64'h2AAA_AAAA_AAAA_AAAA
		};
		for (int i = 0; i < N_RANDOM; i++)
			pending_operands.push_back(random_operand());
		@(posedge arst_n);
		while (pending_operands.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_roots.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (mismatches == 0)
			$display("q32_32_square_root regression: pass");
		else
			$display("q32_32_square_root regression: fail");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("q32_32_square_root regression: fail");
		$finish;
	end

	// operand driver and predictor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			in_operand <= '0;
		end else begin
			if (in_valid && arg_ch.ready) begin
				expected_roots.push_back(expected_root(in_operand));
				sent <= sent + 1;
			end
			if (!in_valid || arg_ch.ready) begin
				if (pending_operands.size() != 0 && (calm || $urandom_range(99) >= 32)) begin
					in_valid   <= 1'b1;
					in_operand <= pending_operands.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, once, to back the pipeline up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && sent >= HOLD_AT) begin
			hold_left <= HOLD_CYC;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 32);
	end

	// result monitor
	always @(posedge clk) begin
		root_rec_t e;
		if (arst_n && res_ch.valid && out_ready) begin
			if (expected_roots.size() == 0) begin
				$display("%0t: unexpected result transfer: root %h invalid %b",
					$time, res_ch.root, res_ch.invalid);
				mismatches <= mismatches + 1;
			end else begin
				e = expected_roots.pop_front();
				if (res_ch.root !== e.root || res_ch.invalid !== e.invalid) begin
					if (res_ch.root !== e.root)
						$display("%0t: root mismatch, operand %h: expected %h, actual %h",
							$time, e.operand, e.root, res_ch.root);
					if (res_ch.invalid !== e.invalid)
						$display("%0t: invalid mismatch, operand %h: expected %b, actual %b",
							$time, e.operand, e.invalid, res_ch.invalid);
					mismatches <= mismatches + 1;
				end
			end
		end
	end

endmodule

// ----- sim.f -----
sv/q32sq_pkg.sv
sv/q32sq_ifs.sv
sv/q32sq_step.sv
sv/q32sq_fix.sv
sv/q32sq_round.sv
sv/q32_32_square_root.sv
sim/tb_q32_32_square_root.sv
